@@ rtl/prdbr_pkg.sv @@
package prdbr_pkg;

  // Table and payload dimensions.
  localparam int NUM_RULES     = 8;
  localparam int REPLACE_BYTES = 16;
  localparam int PAYLOAD_BYTES = 65536;

  // Widths that follow from the dimensions and from the fixed field widths.
  localparam int CHAN_W      = 32;
  localparam int START_W     = 16;
  localparam int RULE_W      = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int OFF_W       = (REPLACE_BYTES > 1) ? $clog2(REPLACE_BYTES) : 1;
  localparam int LEN_W       = $clog2(REPLACE_BYTES + 1);
  localparam int STORE_DEPTH = NUM_RULES * REPLACE_BYTES;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int POS_W       = $clog2(PAYLOAD_BYTES);
  localparam int POS_MAX     = PAYLOAD_BYTES - 1;
  localparam int DIFF_W      = ((POS_W > START_W) ? POS_W : START_W) + 1;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_WR_HDR  = 2'd0,
    CMD_WR_BYTE = 2'd1,
    CMD_PKT     = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // Rule header write or table clear towards the rule table.
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [RULE_W-1:0] slot;
    logic [CHAN_W-1:0] chan;
    logic [START_W-1:0] start;
    logic              kill;
    logic [LEN_W-1:0]  len;
  } rule_wr_t;

  // Lookup result from the rule table.
  typedef struct packed {
    logic                drop;
    logic                hit;
    logic [STORE_AW-1:0] addr;
  } rule_hit_t;

endpackage

@@ rtl/prdbr_in_if.sv @@
interface prdbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  rule_slot;
  logic [31:0] rule_channel;
  logic [15:0] rule_offset;
  logic        rule_drop;
  logic [4:0]  rule_length;
  logic [3:0]  byte_slot;
  logic [7:0]  byte_value;
  logic [31:0] pkt_channel;
  logic        first_byte;
  logic        last_byte;

  modport source (
    output valid, cmd, rule_slot, rule_channel, rule_offset, rule_drop, rule_length,
    output byte_slot, byte_value, pkt_channel, first_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, rule_slot, rule_channel, rule_offset, rule_drop, rule_length,
    input  byte_slot, byte_value, pkt_channel, first_byte, last_byte,
    output ready
  );
endinterface

@@ rtl/prdbr_out_if.sv @@
interface prdbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_replaced;

  modport source (
    output valid, out_byte, out_last, out_replaced,
    input  ready
  );

  modport sink (
    input  valid, out_byte, out_last, out_replaced,
    output ready
  );
endinterface

@@ rtl/prdbr_ram.sv @@
module prdbr_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/prdbr_rule_table.sv @@
module prdbr_rule_table import prdbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rule_wr_t          wr,
  input  logic [CHAN_W-1:0] look_chan,
  input  logic [POS_W-1:0]  look_pos,
  output rule_hit_t         hit
);

  logic [NUM_RULES-1:0] valid_r;
  logic [CHAN_W-1:0]    chan_r  [NUM_RULES];
  logic [START_W-1:0]   start_r [NUM_RULES];
  logic                 kill_r  [NUM_RULES];
  logic [LEN_W-1:0]     len_r   [NUM_RULES];

  // Valid bits: set by a header write, cleared all at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.clr) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.slot] <= 1'b1;
    end
  end

  // Rule header fields keep their values over a clear.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      chan_r[wr.slot]  <= wr.chan;
      start_r[wr.slot] <= wr.start;
      kill_r[wr.slot]  <= wr.kill;
      len_r[wr.slot]   <= wr.len;
    end
  end

  // Parallel compare of every rule; the highest-numbered match wins.
  always_comb begin
    logic [DIFF_W-1:0] diff;
    logic              chan_eq;
    logic [RULE_W-1:0] idx;
    logic [OFF_W-1:0]  off;
    hit.drop = 1'b0;
    hit.hit  = 1'b0;
    idx      = '0;
    off      = '0;
    for (int r = 0; r < NUM_RULES; r++) begin
      chan_eq = valid_r[r] && (chan_r[r] == look_chan);
      diff = {1'b0, (DIFF_W-1)'(look_pos)} - {1'b0, (DIFF_W-1)'(start_r[r])};
      if (chan_eq && kill_r[r]) begin
        hit.drop = 1'b1;
      end
      if (chan_eq && !kill_r[r] && !diff[DIFF_W-1] &&
          (diff[DIFF_W-2:0] < (DIFF_W-1)'(len_r[r]))) begin
        hit.hit = 1'b1;
        idx     = RULE_W'(r);
        off     = diff[OFF_W-1:0];
      end
    end
    hit.addr = STORE_AW'(int'(idx) * REPLACE_BYTES + int'(off));
  end

endmodule

@@ rtl/packet_rule_drop_and_byte_rewrite.sv @@
// Packet rule filter: one item is taken every cycle, whatever its command, as long
// as in_ch.ready is high. A packet byte that is not dropped goes through the rule
// compare and the replacement store read on its way into the stage register, and
// then into the output register. The replacement bytes live in a synchronous
// memory of NUM_RULES x REPLACE_BYTES entries with one write and one read port;
// rule headers sit in registers and are compared in parallel. There is no
// clearing pass after reset: the rule valid bits are cleared at once, so items
// are accepted straight away. A stalled result holds the pipeline only once both
// the stage register and the output register are full.
module packet_rule_drop_and_byte_rewrite import prdbr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  prdbr_in_if.sink  in_ch,
  prdbr_out_if.source out_ch
);

  logic      in_fire;
  logic      pkt_fire;
  logic      pass_fire;
  logic      s1_move;
  rule_wr_t  rule_wr;
  rule_hit_t rule_hit;

  logic             byte_we;
  logic [STORE_AW-1:0] byte_waddr;
  logic [7:0]       rd_data;

  logic [POS_W-1:0] pos_cur;
  logic             drop_cur;

  logic [POS_W-1:0] bpos_r, bpos_nxt;
  logic             dropped_r, dropped_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic             s1_repl_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_repl_r;

  // Handshake: the stage register frees when the output register can take it.
  assign s1_move     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pkt_fire    = in_fire && (in_ch.cmd == CMD_PKT);

  // Rule header writes and clears.
  always_comb begin
    rule_wr.we    = in_fire && (in_ch.cmd == CMD_WR_HDR) &&
                    (int'(in_ch.rule_slot) < NUM_RULES);
    rule_wr.clr   = in_fire && (in_ch.cmd == CMD_CLEAR);
    rule_wr.slot  = RULE_W'(in_ch.rule_slot);
    rule_wr.chan  = in_ch.rule_channel;
    rule_wr.start = in_ch.rule_offset;
    rule_wr.kill  = in_ch.rule_drop;
    rule_wr.len   = (int'(in_ch.rule_length) > REPLACE_BYTES) ?
                    LEN_W'(REPLACE_BYTES) : LEN_W'(in_ch.rule_length);
  end

  // Replacement byte writes.
  assign byte_we    = in_fire && (in_ch.cmd == CMD_WR_BYTE) &&
                      (int'(in_ch.rule_slot) < NUM_RULES) &&
                      (int'(in_ch.byte_slot) < REPLACE_BYTES);
  assign byte_waddr = STORE_AW'(int'(in_ch.rule_slot) * REPLACE_BYTES +
                                int'(in_ch.byte_slot));

  // Position and drop state seen by the current packet byte.
  assign pos_cur  = in_ch.first_byte ? '0 : bpos_r;
  assign drop_cur = in_ch.first_byte ? rule_hit.drop : dropped_r;
  assign pass_fire = pkt_fire && !drop_cur;

  prdbr_rule_table u_rule_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (rule_wr),
    .look_chan (in_ch.pkt_channel),
    .look_pos  (pos_cur),
    .hit       (rule_hit)
  );

  prdbr_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_replace_mem (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (in_ch.byte_value),
    .re    (pkt_fire && rule_hit.hit),
    .raddr (rule_hit.addr),
    .rdata (rd_data)
  );

  // Next-state logic for the position counter and the pipeline.
  always_comb begin
    bpos_nxt      = bpos_r;
    dropped_nxt   = dropped_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (pkt_fire) begin
      dropped_nxt = drop_cur;
      bpos_nxt    = (pos_cur < POS_W'(POS_MAX)) ? pos_cur + POS_W'(1) : pos_cur;
    end
    if (s1_move) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (pass_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r      <= '0;
      dropped_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bpos_r      <= bpos_nxt;
      dropped_r   <= dropped_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage register: the byte waits here for the memory read data.
  always_ff @(posedge clk) begin
    if (pass_fire) begin
      s1_byte_r <= in_ch.byte_value;
      s1_last_r <= in_ch.last_byte;
      s1_repl_r <= rule_hit.hit;
    end
  end

  // Output register: the replacement byte is chosen on the way in.
  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_byte_r <= s1_repl_r ? rd_data : s1_byte_r;
      out_last_r <= s1_last_r;
      out_repl_r <= s1_repl_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.out_last     = out_last_r;
  assign out_ch.out_replaced = out_repl_r;

endmodule
